FILE: src/dlpc_pkg.sv
package dlpc_pkg;

  // Encoder count width and derived datapath widths
  localparam int COUNT_BITS = 20;
  localparam int POS_W      = COUNT_BITS + 1;
  localparam int SP_W       = 21;
  localparam int DELTA_W    = 16;
  localparam int PGAIN_W    = 16;
  localparam int IGAIN_W    = 32;
  localparam int DOFF_W     = 23;
  localparam int POWER_W    = 8;

  // Average position in Q.8: (posL + posR) * 128
  localparam int AVG_W = COUNT_BITS + 9;
  // Button or hold target in Q.8, before truncation
  localparam int TQ_W  = ((AVG_W > DOFF_W + 1) ? AVG_W : DOFF_W + 1) + 1;
  // Setpoint arithmetic width, wide enough for clamping and adding the delta
  localparam int SQ_W  = ((TQ_W - 8 > SP_W) ? TQ_W - 8 : SP_W) + 1;

  // PI datapath widths
  localparam int ERR_W = ((POS_W > SP_W) ? POS_W : SP_W) + 1;
  localparam int ACC_W = 40;
  localparam int IH_W  = ACC_W - 32;
  localparam int PP_W  = ERR_W + PGAIN_W;
  localparam int TL_W  = 62;
  localparam int PT_W  = (PP_W + 16 > TL_W) ? PP_W + 16 : TL_W;
  localparam int IT_W  = (ACC_W + IGAIN_W > TL_W) ? ACC_W + IGAIN_W : TL_W;
  localparam int TM_W  = TL_W + 1;
  localparam int SUM_W = TM_W + 1;
  localparam int Q_W   = SUM_W - 24;

  // Stream packing
  localparam int IN_BITS    = 2 * COUNT_BITS + 3 + DELTA_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * POWER_W + SP_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 2'd0,
    REG_INTEGRAL_GAIN = 2'd1,
    REG_DRIVE_OFFSET  = 2'd2
  } cfg_reg_t;

  localparam logic [PGAIN_W-1:0] PROP_GAIN_RST     = PGAIN_W'(2560);
  localparam logic [IGAIN_W-1:0] INTEGRAL_GAIN_RST = '0;
  localparam logic [DOFF_W-1:0]  DRIVE_OFFSET_RST  = DOFF_W'(3251);

  // Direction of the last button press
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_RAISE = 2'd1,
    DIR_LOWER = 2'd2
  } dir_t;

  // Hold lead of 5 counts in Q.8
  localparam logic signed [TQ_W-1:0] HOLD_STEP_Q8 = TQ_W'(5 * 256);

  // Setpoint limits in the setpoint arithmetic width
  localparam logic signed [SQ_W-1:0] SP_HI = SQ_W'((1 << (SP_W - 1)) - 1);
  localparam logic signed [SQ_W-1:0] SP_LO = ~SP_HI;

  // Product term limit 2^61 in Q.24 units
  localparam logic [PT_W-1:0] P_LIMIT = PT_W'(1) << (TL_W - 1);
  localparam logic [IT_W-1:0] I_LIMIT = IT_W'(1) << (TL_W - 1);

  localparam logic signed [Q_W-1:0] PWR_HI = Q_W'(127);
  localparam logic signed [Q_W-1:0] PWR_LO = -Q_W'(127);

  // Pipeline advance controls handed to each PI side
  typedef struct packed {
    logic take;  // stage 2 takes a valid item (integrator update)
    logic en3;
    logic en4;
    logic en5;
  } dlpc_adv_t;

  // Saturate to the 21-bit setpoint range
  function automatic logic signed [SP_W-1:0] sat_sp(input logic signed [SQ_W-1:0] v);
    logic signed [SQ_W-1:0] c;
    c = (v > SP_HI) ? SP_HI : ((v < SP_LO) ? SP_LO : v);
    return c[SP_W-1:0];
  endfunction

  // Divide a Q.8 value by 256, truncating toward zero
  function automatic logic signed [TQ_W-9:0] div8_trunc(input logic signed [TQ_W-1:0] v);
    logic signed [TQ_W-1:0] adj;
    adj = v + (v[TQ_W-1] ? TQ_W'(255) : '0);
    return adj[TQ_W-1:8];
  endfunction

endpackage

FILE: src/dlpc_pi_side.sv
module dlpc_pi_side (
  input  logic                               clk,
  input  logic                               rst,
  input  dlpc_pkg::dlpc_adv_t                adv,
  input  logic signed [dlpc_pkg::SP_W-1:0]   setpoint,
  input  logic signed [dlpc_pkg::POS_W-1:0]  position,
  input  logic [dlpc_pkg::PGAIN_W-1:0]       prop_gain,
  input  logic [dlpc_pkg::IGAIN_W-1:0]       integral_gain,
  output logic signed [dlpc_pkg::POWER_W-1:0] power
);
  import dlpc_pkg::*;

  // Stage 2: error and saturating integrator
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   err_next;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_next;
  logic signed [ACC_W:0]     acc_sum;

  always_comb begin
    err_next = ERR_W'(setpoint) - ERR_W'(position);
    acc_sum  = (ACC_W + 1)'(acc) + (ACC_W + 1)'(err_next);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      acc_next = acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv.take) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.take) begin
      err <= err_next;
    end
  end

  // Stage 3: magnitude products, integral split into two partial products
  logic [ERR_W-1:0]           err_mag;
  logic [ACC_W-1:0]           acc_mag;
  logic [PP_W-1:0]            p_prod;
  logic [63:0]                i_lo;
  logic [IH_W+IGAIN_W-1:0]    i_hi;
  logic                       err_neg;
  logic                       acc_neg;

  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  always_ff @(posedge clk) begin
    if (adv.en3) begin
      p_prod  <= PP_W'(err_mag) * PP_W'(prop_gain);
      i_lo    <= 64'(acc_mag[31:0]) * 64'(integral_gain);
      i_hi    <= (IH_W + IGAIN_W)'(acc_mag[ACC_W-1:32]) * (IH_W + IGAIN_W)'(integral_gain);
      err_neg <= err[ERR_W-1];
      acc_neg <= acc[ACC_W-1];
    end
  end

  // Stage 4: saturate each term at 2^61 and apply sign
  logic [PT_W-1:0]         p_full;
  logic [IT_W-1:0]         i_full;
  logic [TL_W-1:0]         p_mag;
  logic [TL_W-1:0]         i_mag;
  logic signed [TM_W-1:0]  p_term;
  logic signed [TM_W-1:0]  i_term;

  always_comb begin
    p_full = PT_W'({p_prod, 16'b0});
    i_full = IT_W'({i_hi, 32'b0}) + IT_W'(i_lo);
    p_mag  = (p_full > P_LIMIT) ? TL_W'(P_LIMIT) : TL_W'(p_full);
    i_mag  = (i_full > I_LIMIT) ? TL_W'(I_LIMIT) : TL_W'(i_full);
  end

  always_ff @(posedge clk) begin
    if (adv.en4) begin
      p_term <= err_neg ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
      i_term <= acc_neg ? -$signed({1'b0, i_mag}) : $signed({1'b0, i_mag});
    end
  end

  // Stage 5: sum, truncate toward zero by 2^24, clamp to +-127
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_adj;
  logic signed [Q_W-1:0]   q;
  logic signed [Q_W-1:0]   q_sat;

  always_comb begin
    sum     = SUM_W'(p_term) + SUM_W'(i_term);
    sum_adj = sum + (sum[SUM_W-1] ? SUM_W'(24'hFF_FFFF) : '0);
    q       = sum_adj[SUM_W-1:24];
    q_sat   = (q > PWR_HI) ? PWR_HI : ((q < PWR_LO) ? PWR_LO : q);
  end

  always_ff @(posedge clk) begin
    if (adv.en5) begin
      power <= q_sat[POWER_W-1:0];
    end
  end

endmodule

FILE: src/dual_lift_pi_position_control.sv
// An accepted request passes stage registers 0 to 5; stage 5 drives m_tvalid.
// Throughput: one request per cycle unless stalled; six register stages, each
// holds while its successor is full, squeezing out bubbles under back pressure.
// The 40x32 integral product is split into two partial products in stage 3.
// rst (synchronous) clears all stage valids, setpoint, direction, hold flag
// and both integrators, and restores the gain and offset registers.
module dual_lift_pi_position_control (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input requests
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // left_count, right_count, operator_mode, lower_request, raise_request,
  // setpoint_delta (from bit 0 up)
  input  logic [dlpc_pkg::IN_TDATA_W-1:0]       s_tdata,
  // Results
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // left_power, right_power, current_setpoint (from bit 0 up)
  output logic [dlpc_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // Configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dlpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dlpc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dlpc_pkg::*;

  // Configuration registers
  logic [PGAIN_W-1:0] prop_gain;
  logic [IGAIN_W-1:0] integral_gain;
  logic [DOFF_W-1:0]  drive_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= PROP_GAIN_RST;
      integral_gain <= INTEGRAL_GAIN_RST;
      drive_offset  <= DRIVE_OFFSET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROP_GAIN:     prop_gain     <= cfg_data[PGAIN_W-1:0];
        REG_INTEGRAL_GAIN: integral_gain <= cfg_data[IGAIN_W-1:0];
        REG_DRIVE_OFFSET:  drive_offset  <= cfg_data[DOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids and advance enables
  logic v0, v1, v2, v3, v4, v5;
  logic en0, en1, en2, en3, en4, en5;

  assign en5      = !v5 || m_tready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign s_tready = en0;
  assign m_tvalid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en0) v0 <= s_tvalid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 0: input register
  logic signed [COUNT_BITS-1:0] left_count;
  logic signed [COUNT_BITS-1:0] right_count;
  logic                         operator_mode;
  logic                         lower_request;
  logic                         raise_request;
  logic signed [DELTA_W-1:0]    setpoint_delta;

  always_ff @(posedge clk) begin
    if (en0) begin
      left_count     <= s_tdata[COUNT_BITS-1:0];
      right_count    <= s_tdata[2*COUNT_BITS-1:COUNT_BITS];
      operator_mode  <= s_tdata[2*COUNT_BITS];
      lower_request  <= s_tdata[2*COUNT_BITS+1];
      raise_request  <= s_tdata[2*COUNT_BITS+2];
      setpoint_delta <= s_tdata[2*COUNT_BITS+3+:DELTA_W];
    end
  end

  // Stage 1: positions and setpoint update
  logic signed [POS_W-1:0]  pos_l_next;
  logic signed [POS_W-1:0]  pos_r_next;
  logic signed [POS_W:0]    pos_sum;
  logic signed [AVG_W-1:0]  avg_q8;
  logic signed [TQ_W-1:0]   base_q8;
  logic signed [TQ_W-1:0]   offs_q8;
  logic signed [TQ_W-1:0]   tgt_q8;
  logic                     tgt_load;
  logic signed [SP_W-1:0]   pre_sp;
  logic signed [SP_W-1:0]   target_next;
  dir_t                     dir_next;
  logic                     holding_next;

  logic signed [SP_W-1:0]   target_position;
  logic signed [POS_W-1:0]  pos_l;
  logic signed [POS_W-1:0]  pos_r;
  dir_t                     last_direction;
  logic                     holding;

  always_comb begin
    pos_l_next   = -POS_W'(left_count);
    pos_r_next   = -POS_W'(right_count);
    pos_sum      = (POS_W + 1)'(pos_l_next) + (POS_W + 1)'(pos_r_next);
    avg_q8       = {pos_sum, 7'b0};
    base_q8      = TQ_W'(avg_q8);
    offs_q8      = $signed(TQ_W'(drive_offset));
    tgt_q8       = base_q8;
    tgt_load     = 1'b0;
    dir_next     = last_direction;
    holding_next = holding;
    if (operator_mode) begin
      if (lower_request) begin
        tgt_q8       = base_q8 - offs_q8;
        tgt_load     = 1'b1;
        dir_next     = DIR_LOWER;
        holding_next = 1'b0;
      end else if (raise_request) begin
        tgt_q8       = base_q8 + offs_q8;
        tgt_load     = 1'b1;
        dir_next     = DIR_RAISE;
        holding_next = 1'b0;
      end else begin
        // hold pass runs once after release
        if (!holding) begin
          tgt_load = 1'b1;
          case (last_direction)
            DIR_RAISE: tgt_q8 = base_q8 + HOLD_STEP_Q8;
            DIR_LOWER: tgt_q8 = base_q8 - HOLD_STEP_Q8;
            default:   tgt_q8 = base_q8;
          endcase
        end
        holding_next = 1'b1;
      end
    end
    pre_sp      = tgt_load ? sat_sp(SQ_W'(div8_trunc(tgt_q8))) : target_position;
    target_next = sat_sp(SQ_W'(pre_sp) + SQ_W'(setpoint_delta));
  end

  // target_position doubles as the stage 1 setpoint payload
  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      last_direction  <= DIR_NONE;
      holding         <= 1'b0;
    end else if (v0 && en1) begin
      target_position <= target_next;
      last_direction  <= dir_next;
      holding         <= holding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (v0 && en1) begin
      pos_l <= pos_l_next;
      pos_r <= pos_r_next;
    end
  end

  // Setpoint travels alongside the PI stages
  logic signed [SP_W-1:0] sp2, sp3, sp4, sp5;

  always_ff @(posedge clk) begin
    if (en2) sp2 <= target_position;
    if (en3) sp3 <= sp2;
    if (en4) sp4 <= sp3;
    if (en5) sp5 <= sp4;
  end

  // Two PI loops
  dlpc_adv_t                  adv;
  logic signed [POWER_W-1:0]  left_power;
  logic signed [POWER_W-1:0]  right_power;

  assign adv.take = v1 && en2;
  assign adv.en3  = en3;
  assign adv.en4  = en4;
  assign adv.en5  = en5;

  dlpc_pi_side u_left (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .setpoint      (target_position),
    .position      (pos_l),
    .prop_gain     (prop_gain),
    .integral_gain (integral_gain),
    .power         (left_power)
  );

  dlpc_pi_side u_right (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .setpoint      (target_position),
    .position      (pos_r),
    .prop_gain     (prop_gain),
    .integral_gain (integral_gain),
    .power         (right_power)
  );

  assign m_tdata = OUT_TDATA_W'({sp5, right_power, left_power});

endmodule

FILE: tb/tb_dual_lift_pi_position_control.sv
module tb_dual_lift_pi_position_control;
  import dlpc_pkg::*;

  typedef longint unsigned u64_t;

  // Result fields, packed so the low 37 bits of m_tdata cast straight in
  typedef struct packed {
    logic signed [SP_W-1:0]    setpoint;
    logic signed [POWER_W-1:0] right_power;
    logic signed [POWER_W-1:0] left_power;
  } drive_t;

  localparam longint ACC_TOP      = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_BOT      = -ACC_TOP - 1;
  localparam u64_t   TERM_LIM     = u64_t'(P_LIMIT);
  localparam longint SP_TOP       = longint'(SP_HI);
  localparam longint SP_BOT       = longint'(SP_LO);
  localparam longint HOLD_LEAD    = longint'(HOLD_STEP_Q8);
  localparam int     CHOKE_AT     = 800;
  localparam int     CHOKE_CYCLES = 120;
  localparam int     LIMIT        = 200000;

  // Tracks setpoint, button state and both integrators; predicts each tick
  class lift_drive_scoreboard;
    bit [PGAIN_W-1:0] prop_gain;
    bit [IGAIN_W-1:0] integral_gain;
    bit [DOFF_W-1:0]  drive_offset;
    longint setpoint;
    dir_t   last_dir;
    bit     holding;
    longint acc_l;
    longint acc_r;
    drive_t expected_drive[$];
    int     errors;
    int     checked;

    function new();
      prop_gain     = PROP_GAIN_RST;
      integral_gain = INTEGRAL_GAIN_RST;
      drive_offset  = DRIVE_OFFSET_RST;
      setpoint      = 0;
      last_dir      = DIR_NONE;
      holding       = 1'b0;
      acc_l         = 0;
      acc_r         = 0;
      errors        = 0;
      checked       = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_PROP_GAIN:     prop_gain = v[PGAIN_W-1:0];
        REG_INTEGRAL_GAIN: integral_gain = v[IGAIN_W-1:0];
        REG_DRIVE_OFFSET:  drive_offset = v[DOFF_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Divide by 2^sh, rounding toward zero
    function longint trunc_div(longint v, int sh);
      u64_t m;
      m = (v < 0) ? -v : v;
      m = m >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // Signed value times unsigned gain, magnitude capped at 2^61
    function longint scaled_term(longint v, u64_t g);
      u64_t m, p;
      m = (v < 0) ? -v : v;
      if (m == 0 || g == 0) return 0;
      p = (g > TERM_LIM / m) ? TERM_LIM : m * g;
      return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    function logic signed [POWER_W-1:0] side_power(longint pos, inout longint acc);
      longint err, total, q;
      u64_t   pg;
      err   = setpoint - pos;
      acc   = clamp(acc + err, ACC_BOT, ACC_TOP);
      pg    = prop_gain;
      pg    = pg << 16;
      total = scaled_term(err, pg) + scaled_term(acc, integral_gain);
      q     = clamp(trunc_div(total, 24), -127, 127);
      return q[POWER_W-1:0];
    endfunction

    // Accepted request: advance the setpoint rules and both PI loops
    function void note_request(logic [IN_TDATA_W-1:0] d);
      longint pos_l, pos_r, delta, avg_q8, t;
      bit     op, lower_req, raise_req;
      drive_t want;
      pos_l     = -longint'($signed(d[COUNT_BITS-1:0]));
      pos_r     = -longint'($signed(d[2*COUNT_BITS-1:COUNT_BITS]));
      op        = d[2*COUNT_BITS];
      lower_req = d[2*COUNT_BITS+1];
      raise_req = d[2*COUNT_BITS+2];
      delta     = longint'($signed(d[2*COUNT_BITS+3 +: DELTA_W]));
      avg_q8    = (pos_l + pos_r) * 128;
      if (op) begin
        if (lower_req) begin
          setpoint = clamp(trunc_div(avg_q8 - longint'(drive_offset), 8), SP_BOT, SP_TOP);
          last_dir = DIR_LOWER;
          holding  = 1'b0;
        end else if (raise_req) begin
          setpoint = clamp(trunc_div(avg_q8 + longint'(drive_offset), 8), SP_BOT, SP_TOP);
          last_dir = DIR_RAISE;
          holding  = 1'b0;
        end else begin
          // one hold pass after release
          if (!holding) begin
            t = avg_q8;
            if (last_dir == DIR_RAISE) t = t + HOLD_LEAD;
            else if (last_dir == DIR_LOWER) t = t - HOLD_LEAD;
            setpoint = clamp(trunc_div(t, 8), SP_BOT, SP_TOP);
          end
          holding = 1'b1;
        end
      end
      setpoint         = clamp(setpoint + delta, SP_BOT, SP_TOP);
      want.left_power  = side_power(pos_l, acc_l);
      want.right_power = side_power(pos_r, acc_r);
      want.setpoint    = setpoint[SP_W-1:0];
      expected_drive.push_back(want);
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Accepted result: compare against the oldest prediction
    function void check_result(logic [OUT_TDATA_W-1:0] d);
      drive_t got, want;
      got = d[OUT_BITS-1:0];
      if (expected_drive.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none, actual %0d %0d %0d",
                 $time, got.left_power, got.right_power, got.setpoint);
        return;
      end
      want = expected_drive.pop_front();
      checked++;
      if (got.left_power !== want.left_power)
        report("left_power", want.left_power, got.left_power);
      if (got.right_power !== want.right_power)
        report("right_power", want.right_power, got.right_power);
      if (got.setpoint !== want.setpoint)
        report("current_setpoint", want.setpoint, got.setpoint);
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  // left_count, right_count, operator_mode, lower_request, raise_request,
  // setpoint_delta (from bit 0 up)
  logic [IN_TDATA_W-1:0]   s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  // left_power, right_power, current_setpoint (from bit 0 up)
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  lift_drive_scoreboard sb;
  bit steady;
  bit choke_done;
  int inputs_taken;
  int n_settings;
  int cycles;

  // Stimulus generator state
  int base_pos;
  int run_left;
  int run_kind;
  int surge_left;
  bit surge_up;

  dual_lift_pi_position_control dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_dual_lift_pi_position_control: FAIL");
    $finish;
  end

  // Sample all handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) begin
        sb.note_request(s_tdata);
        inputs_taken++;
      end
      if (cfg_valid && cfg_ready) sb.set_register(cfg_reg_t'(cfg_index), cfg_data);
    end
  end

  // Result side: random back pressure, one long hold-off to fill the pipe
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!choke_done && inputs_taken >= CHOKE_AT) begin
        choke_done = 1'b1;
        m_tready <= 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
      end
      m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 14);
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_tick(logic signed [31:0] lc,
      logic signed [31:0] rc, bit op, bit lo, bit ra, logic signed [31:0] dl);
    return IN_TDATA_W'({dl[DELTA_W-1:0], ra, lo, op, rc[COUNT_BITS-1:0],
                        lc[COUNT_BITS-1:0]});
  endfunction

  // Offer one request and hold it until taken; returns at a falling edge
  task automatic send_tick(input logic [IN_TDATA_W-1:0] d);
    if (!steady && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Wait until every prediction is matched and the pipe has emptied
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_drive.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic post_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] pg,
      input logic [CFG_DATA_W-1:0] ig, input logic [CFG_DATA_W-1:0] doff);
    drain();
    post_register(REG_PROP_GAIN, pg);
    post_register(REG_INTEGRAL_GAIN, ig);
    post_register(REG_DRIVE_OFFSET, doff);
    n_settings++;
  endtask

  // Extremes, every button rule, truncation and hold cases at reset settings
  task automatic directed_ticks();
    send_tick(pack_tick(100, -100, 1, 0, 0, 0));           // hold with no direction
    send_tick(pack_tick(-1000, -1003, 1, 0, 1, 0));        // raise
    send_tick(pack_tick(-1010, -1013, 1, 0, 1, 0));
    send_tick(pack_tick(-1010, -1013, 1, 0, 0, 0));        // release after raise
    send_tick(pack_tick(-1012, -1011, 1, 0, 0, 0));        // already holding
    send_tick(pack_tick(-900, -899, 1, 1, 0, 0));          // lower
    send_tick(pack_tick(-880, -881, 1, 1, 1, 0));          // lower wins over raise
    send_tick(pack_tick(-870, -870, 1, 0, 0, 0));          // release after lower
    send_tick(pack_tick(-860, -850, 0, 0, 1, 0));          // buttons ignored
    send_tick(pack_tick(-860, -850, 0, 1, 0, 100));
    send_tick(pack_tick(-524288, -524288, 1, 0, 1, 0));    // largest positions
    send_tick(pack_tick(524287, 524287, 0, 0, 0, 32767));
    send_tick(pack_tick(-524288, 524287, 0, 0, 0, -32768));
    send_tick(pack_tick(524287, 524287, 1, 1, 0, 0));
    send_tick(pack_tick(0, 0, 1, 0, 0, 0));
    send_tick(pack_tick(0, 0, 0, 0, 0, 0));
    send_tick(pack_tick(-1, 0, 1, 0, 1, 0));
    send_tick(pack_tick(1, 0, 1, 0, 0, 0));                // positive truncation
    send_tick(pack_tick(1, 0, 1, 1, 0, 0));                // negative truncation
    send_tick(pack_tick(1, 2, 1, 0, 0, 0));
    send_tick(pack_tick(-7, 9, 1, 1, 1, -1));
  endtask

  // Mostly press/hold/release runs near a drifting position, some delta
  // surges to saturate the setpoint, and fully random noise
  task automatic random_ticks(input int n, input int calm_from, input int calm_to);
    logic [IN_TDATA_W-1:0] d;
    int pl, pr, dl;
    bit op;
    for (int i = 0; i < n; i++) begin
      steady = (i >= calm_from && i < calm_to);
      if (surge_left > 0) begin
        surge_left--;
        dl = surge_up ? int'($urandom_range(32000, 32767)) : -int'($urandom_range(32000, 32768));
        d  = pack_tick(-base_pos, -base_pos - 3, 0, 1'($urandom_range(1)),
                       1'($urandom_range(1)), dl);
      end else if ($urandom_range(99) < 72) begin
        if (run_left == 0) begin
          if ($urandom_range(59) == 0) begin
            surge_left = 30;
            surge_up   = 1'($urandom_range(1));
          end
          run_kind = $urandom_range(3);
          run_left = $urandom_range(1, 6);
        end
        run_left--;
        base_pos = base_pos + int'($urandom_range(40)) - 20;
        if (base_pos > 520000) base_pos = 520000;
        if (base_pos < -520000) base_pos = -520000;
        pl = base_pos + int'($urandom_range(16)) - 8;
        pr = base_pos + int'($urandom_range(16)) - 8;
        op = ($urandom_range(9) != 0);
        if ($urandom_range(49) == 0) dl = int'($urandom_range(65535)) - 32768;
        else if ($urandom_range(3) == 0) dl = int'($urandom_range(20)) - 10;
        else dl = 0;
        d = pack_tick(-pl, -pr, op, run_kind >= 2, run_kind[0], dl);
      end else begin
        d = {$urandom, $urandom};
        d[IN_TDATA_W-1:IN_BITS] = '0;
      end
      send_tick(d);
    end
    steady = 1'b0;
  endtask

  initial begin
    sb           = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_PROP_GAIN;
    cfg_data     = '0;
    steady       = 1'b0;
    choke_done   = 1'b0;
    inputs_taken = 0;
    n_settings   = 1;
    base_pos     = 0;
    run_left     = 0;
    run_kind     = 0;
    surge_left   = 0;
    surge_up     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_ticks();
    apply_settings(32'h0000_FFFF, 32'h0, 32'h0);
    random_ticks(300, 0, 0);
    apply_settings(32'h0, 32'hFFFF_FFFF, 32'h007F_FFFF);
    random_ticks(250, 0, 0);
    // default-like gains; quiet stretch overlaps the long output hold-off
    apply_settings(32'd2560, 32'd4096, 32'd3251);
    random_ticks(400, 150, 350);
    for (int k = 0; k < 3; k++) begin
      apply_settings($urandom_range(1024), $urandom_range(1 << 20), $urandom_range(20000));
      random_ticks(230, 0, 0);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Checked %0d control ticks over %0d register settings: button runs, holds,",
             sb.checked, n_settings);
    $display("setpoint saturation surges, random noise and a %0d-cycle output stall.",
             CHOKE_CYCLES);
    if (sb.errors == 0 && sb.expected_drive.size() == 0) begin
      $display("tb_dual_lift_pi_position_control: PASS");
    end else begin
      $display("tb_dual_lift_pi_position_control: FAIL");
    end
    $finish;
  end

endmodule
